### hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define OVL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, held off during reset
`define OVL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### hw/rtl/ovl_pkg.sv
// shared constants of the ordered value list
package ovl_pkg;

  localparam int CMD_W = 2;
  localparam int VAL_W = 32;
  localparam int ST_W = 2;
  localparam int CNT_OUT_W = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  localparam logic [ST_W-1:0] ST_OK = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

endpackage

### hw/rtl/ovl_ram.sv
// generic simple dual-port ram with registered read
module ovl_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### hw/rtl/ordered_value_list_top.sv
// ordered value list: append, remove first match, search over a ram
//
// channel  | handshake         | fields
// ---------+-------------------+------------------------------------
// command  | start, busy       | command_i, value_i
// result   | done_o (strobe)   | status_o, is_empty_o, entry_count_o
//
// insert and the unused code report in the next cycle and allow a new item at once.
// search reads the ram one entry a cycle into one comparator and stops at the first match.
// remove scans for the first match as search does, then shifts the later
// entries down one place through the same ram.
// reset clears the count and the sequencer; ram contents are never cleared.
// results cannot be stalled; busy stays high while a scan or shift runs.
module ordered_value_list_top #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [ovl_pkg::CMD_W-1:0]          command_i,
  input  logic signed [ovl_pkg::VAL_W-1:0]   value_i,
  output logic                               done_o,
  output logic [ovl_pkg::ST_W-1:0]           status_o,
  output logic                               is_empty_o,
  output logic [ovl_pkg::CNT_OUT_W-1:0]      entry_count_o
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CntW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_e;

  state_e state_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] idx_q;
  logic [CntW-1:0] pidx_q;
  logic pend_q;
  logic [ovl_pkg::CMD_W-1:0] cmd_q;
  logic signed [ovl_pkg::VAL_W-1:0] value_q;
  logic done_q;
  logic [ovl_pkg::ST_W-1:0] status_q;

  logic accept;
  logic issue;
  logic match;
  logic we;
  logic [AW-1:0] waddr;
  logic [ovl_pkg::VAL_W-1:0] wdata;
  logic [ovl_pkg::VAL_W-1:0] rdata;
  logic [CntW-1:0] pidx_m1;
  logic [CntW+ovl_pkg::CNT_OUT_W-1:0] count_ext;

  assign busy = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign issue = (state_q == S_SCAN || state_q == S_SHIFT) && (idx_q < count_q);
  assign match = pend_q && (rdata == value_q);
  assign pidx_m1 = pidx_q - 1'b1;

  always_comb begin
    we = 1'b0;
    waddr = count_q[AW-1:0];
    wdata = value_i;
    if (accept && command_i == ovl_pkg::CMD_INSERT && count_q < MaxCnt) begin
      we = 1'b1;
    end else if (state_q == S_SHIFT && pend_q) begin
      // entry read last cycle moves down one place
      we = 1'b1;
      waddr = pidx_m1[AW-1:0];
      wdata = rdata;
    end
  end

  ovl_ram #(
    .Width(ovl_pkg::VAL_W),
    .Depth(MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q <= '0;
      pidx_q <= '0;
      pend_q <= 1'b0;
      cmd_q <= ovl_pkg::CMD_INSERT;
      value_q <= '0;
      done_q <= 1'b0;
      status_q <= ovl_pkg::ST_OK;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q <= command_i;
            value_q <= value_i;
            idx_q <= '0;
            pend_q <= 1'b0;
            case (command_i)
              ovl_pkg::CMD_INSERT: begin
                done_q <= 1'b1;
                if (count_q < MaxCnt) begin
                  count_q <= count_q + 1'b1;
                  status_q <= ovl_pkg::ST_OK;
                end else begin
                  status_q <= ovl_pkg::ST_FULL;
                end
              end
              ovl_pkg::CMD_REMOVE, ovl_pkg::CMD_SEARCH: begin
                state_q <= S_SCAN;
              end
              default: begin
                done_q <= 1'b1;
                status_q <= ovl_pkg::ST_OK;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (match) begin
            if (cmd_q == ovl_pkg::CMD_SEARCH) begin
              done_q <= 1'b1;
              status_q <= ovl_pkg::ST_OK;
              state_q <= S_IDLE;
            end else begin
              // start shifting from the entry after the match
              state_q <= S_SHIFT;
              idx_q <= pidx_q + 1'b1;
              pend_q <= 1'b0;
            end
          end else if (!issue && !pend_q) begin
            done_q <= 1'b1;
            status_q <= ovl_pkg::ST_NOT_FOUND;
            state_q <= S_IDLE;
          end else begin
            idx_q <= idx_q + CntW'(issue);
            pend_q <= issue;
            pidx_q <= idx_q;
          end
        end
        S_SHIFT: begin
          if (!issue && !pend_q) begin
            count_q <= count_q - 1'b1;
            done_q <= 1'b1;
            status_q <= ovl_pkg::ST_OK;
            state_q <= S_IDLE;
          end else begin
            idx_q <= idx_q + CntW'(issue);
            pend_q <= issue;
            pidx_q <= idx_q;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign count_ext = {{ovl_pkg::CNT_OUT_W{1'b0}}, count_q};
  assign done_o = done_q;
  assign status_o = status_q;
  assign is_empty_o = (count_q == '0);
  assign entry_count_o = count_ext[ovl_pkg::CNT_OUT_W-1:0];

endmodule

### hw/rtl/ovl_checker.sv
// port-level checks of the ordered value list, bound to the top level
`include "assert_macros.svh"

module ovl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic [ovl_pkg::CMD_W-1:0]     command_i,
  input logic                          done_o,
  input logic [ovl_pkg::ST_W-1:0]      status_o,
  input logic                          is_empty_o
);

  logic accepted;
  assign accepted = start && !busy;

  // an accepted item either finishes next cycle or keeps the block busy
  `OVL_ASSERT_NXT(a_item_progress, clk_i, rst_ni, accepted, busy || done_o)
  // busy only drops together with a result
  `OVL_ASSERT_IMP(a_busy_drop_result, clk_i, rst_ni, $fell(busy), done_o)
  // a full report means the list cannot be empty
  `OVL_ASSERT_IMP(a_full_not_empty, clk_i, rst_ni,
    done_o && status_o == ovl_pkg::ST_FULL, !is_empty_o)
  // only insert can report full
  `OVL_ASSERT_NXT(a_full_from_insert, clk_i, rst_ni,
    accepted && command_i != ovl_pkg::CMD_INSERT, !(done_o && status_o == ovl_pkg::ST_FULL))

endmodule

bind ordered_value_list_top ovl_checker u_ovl_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .command_i  (command_i),
  .done_o     (done_o),
  .status_o   (status_o),
  .is_empty_o (is_empty_o)
);

### verif/tb_ordered_value_list_top.sv
// testbench for the ordered value list: command items checked against a queue-based model
`timescale 1ns / 1ps

module tb_ordered_value_list_top;
  import ovl_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_ITEMS = 1340;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] VAL_NEG1 = -32'sd1;

  typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED} seg_mode_e;

  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] val;
    int unsigned             gap_pct;
  } list_cmd_t;

  typedef struct {
    logic [ST_W-1:0]      status;
    logic                 is_empty;
    logic [CNT_OUT_W-1:0] count;
  } list_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [CMD_W-1:0]           command_i = '0;
  logic signed [VAL_W-1:0]    value_i = '0;
  logic                       done_o;
  logic [ST_W-1:0]            status_o;
  logic                       is_empty_o;
  logic [CNT_OUT_W-1:0]       entry_count_o;

  list_cmd_t               pending_cmds[$];
  list_cmd_t               cur_cmd;
  list_result_t            expected_results[$];
  list_result_t            exp_res;
  logic signed [VAL_W-1:0] list_model[$];
  logic signed [VAL_W-1:0] value_pool[10];

  int n_total = 0;
  int n_accepted = 0;
  int n_errors = 0;
  int n_cmd[4] = '{0, 0, 0, 0};
  int n_full = 0;
  int n_miss = 0;
  int peak_count = 0;
  int cycle_cnt = 0;

  ordered_value_list_top #(
    .MAX_ENTRIES(LIST_DEPTH)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .command_i(command_i),
    .value_i(value_i),
    .done_o(done_o),
    .status_o(status_o),
    .is_empty_o(is_empty_o),
    .entry_count_o(entry_count_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // applies one command to the model list and returns the result it should produce
  function automatic list_result_t apply_list_op(input logic [CMD_W-1:0] cmd,
                                                 input logic signed [VAL_W-1:0] val);
    list_result_t res;
    int hit;
    hit = -1;
    res.status = ST_OK;
    for (int i = 0; i < list_model.size(); i++) begin
      if (hit < 0 && list_model[i] == val) hit = i;
    end
    case (cmd)
      CMD_INSERT: begin
        if (list_model.size() >= LIST_DEPTH) res.status = ST_FULL;
        else list_model.push_back(val);
      end
      CMD_REMOVE: begin
        if (hit < 0) res.status = ST_NOT_FOUND;
        else list_model.delete(hit);
      end
      CMD_SEARCH: begin
        res.status = (hit < 0) ? ST_NOT_FOUND : ST_OK;
      end
      default: begin
      end
    endcase
    res.is_empty = (list_model.size() == 0);
    res.count = CNT_OUT_W'(list_model.size());
    return res;
  endfunction

  task automatic add_cmd(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] val,
                         input int unsigned gap_pct);
    list_cmd_t c;
    c.cmd = cmd;
    c.val = val;
    c.gap_pct = gap_pct;
    pending_cmds.push_back(c);
    n_total++;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    if ($urandom_range(99) < 75) return value_pool[$urandom_range(9)];
    return $urandom;
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(input seg_mode_e mode);
    int unsigned r;
    int unsigned ins_lim;
    int unsigned rem_lim;
    r = $urandom_range(99);
    case (mode)
      SEG_FILL: begin
        ins_lim = 70;
        rem_lim = 85;
      end
      SEG_DRAIN: begin
        ins_lim = 15;
        rem_lim = 70;
      end
      default: begin
        ins_lim = 40;
        rem_lim = 70;
      end
    endcase
    if (r < 3) return CMD_UNUSED;
    if (r < ins_lim) return CMD_INSERT;
    if (r < rem_lim) return CMD_REMOVE;
    return CMD_SEARCH;
  endfunction

  task automatic build_stimulus();
    int unsigned phase_gap[4];
    int unsigned gap;
    int seg_len;
    int done_cnt;
    seg_mode_e mode;
    phase_gap = '{0, 49, 0, 23};

    // empty list corner cases
    add_cmd(CMD_SEARCH, 32'sd5, 0);
    add_cmd(CMD_REMOVE, 32'sd5, 0);
    add_cmd(CMD_UNUSED, VAL_MAX, 0);
    // extremes and a duplicate of the oldest entry
    add_cmd(CMD_INSERT, VAL_MIN, 0);
    add_cmd(CMD_INSERT, VAL_MAX, 0);
    add_cmd(CMD_INSERT, VAL_NEG1, 0);
    add_cmd(CMD_INSERT, 32'sd0, 0);
    add_cmd(CMD_INSERT, VAL_MIN, 0);
    add_cmd(CMD_SEARCH, VAL_MAX, 0);
    add_cmd(CMD_SEARCH, 32'sd1, 0);
    // only the oldest duplicate goes, the second one is still found
    add_cmd(CMD_REMOVE, VAL_MIN, 0);
    add_cmd(CMD_SEARCH, VAL_MIN, 0);
    add_cmd(CMD_REMOVE, 32'sh5555_aaaa, 0);
    add_cmd(CMD_UNUSED, VAL_NEG1, 0);
    // fill to capacity, then overflow
    for (int i = 0; i < 12; i++) add_cmd(CMD_INSERT, $urandom, 0);
    add_cmd(CMD_INSERT, 32'sh0f0f_0f0f, 0);
    add_cmd(CMD_REMOVE, VAL_MIN, 0);

    value_pool = '{VAL_MIN, VAL_MAX, VAL_NEG1, 32'sd0, 32'sd1, 0, 0, 0, 0, 0};
    for (int p = 0; p < 4; p++) begin
      done_cnt = 0;
      while (done_cnt < RANDOM_ITEMS / 4) begin
        seg_len = $urandom_range(60, 20);
        mode = seg_mode_e'($urandom_range(2));
        gap = ($urandom_range(3) == 0) ? 0 : phase_gap[p];
        for (int k = 5; k < 10; k++) begin
          if ($urandom_range(1) == 0) value_pool[k] = $urandom;
        end
        for (int j = 0; j < seg_len; j++) add_cmd(pick_cmd(mode), pick_value(), gap);
        done_cnt += seg_len;
      end
    end
  endtask

  // driver: presents the next item once the current one is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(apply_list_op(cur_cmd.cmd, cur_cmd.val));
        n_accepted++;
        n_cmd[cur_cmd.cmd]++;
        if (list_model.size() > peak_count) peak_count = list_model.size();
      end
      if (!start || !busy) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= pending_cmds[0].gap_pct) begin
          cur_cmd = pending_cmds.pop_front();
          start <= 1'b1;
          command_i <= cur_cmd.cmd;
          value_i <= cur_cmd.val;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed result is checked against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("result with no item outstanding: status %0d count %0d",
               status_o, entry_count_o);
        n_errors++;
      end else begin
        exp_res = expected_results.pop_front();
        if (status_o !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, status_o);
          n_errors++;
        end
        if (status_o == ST_FULL) n_full++;
        if (status_o == ST_NOT_FOUND) n_miss++;
        if (is_empty_o !== exp_res.is_empty) begin
          $error("is_empty: expected %0d, got %0d", exp_res.is_empty, is_empty_o);
          n_errors++;
        end
        if (entry_count_o !== exp_res.count) begin
          $error("entry_count: expected %0d, got %0d", exp_res.count, entry_count_o);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (n_accepted == n_total);
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("ran %0d items: %0d insert, %0d remove, %0d search, %0d unused code",
             n_accepted, n_cmd[CMD_INSERT], n_cmd[CMD_REMOVE], n_cmd[CMD_SEARCH],
             n_cmd[CMD_UNUSED]);
    $display("saw %0d full rejects, %0d misses, peak occupancy %0d of %0d",
             n_full, n_miss, peak_count, LIST_DEPTH);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
